>>> hdl/arpc_pkg.sv
// arpc_pkg: shared types, codes and constants for the ARP cache resolver.
// No dependencies.
package arpc_pkg;

   localparam int ENTRIES    = 16;
   localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);

   localparam logic [31:0] CACHE_TIMEOUT_RST  = 32'd60000;
   localparam logic [15:0] QUERY_INTERVAL_RST = 16'd500;
   localparam logic [3:0]  MAX_ATTEMPTS_RST   = 4'd10;
   localparam logic [31:0] FLUSH_INTERVAL_RST = 32'd15000;
   localparam logic [15:0] ARP_HW_ETHER       = 16'h0001;
   localparam logic [15:0] ARP_PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]  ARP_HW_LEN         = 8'd6;
   localparam logic [7:0]  ARP_PROTO_LEN      = 8'd4;
   localparam logic [15:0] ARP_OPC_REQUEST    = 16'd1;
   localparam logic [15:0] ARP_OPC_REPLY      = 16'd2;

   localparam logic [2:0] CSR_LOCAL_IP = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT  = 3'd1;
   localparam logic [2:0] CSR_QUERY    = 3'd2;
   localparam logic [2:0] CSR_ATTEMPTS = 3'd3;
   localparam logic [2:0] CSR_FLUSH    = 3'd4;

   typedef enum logic [1:0] {
      OP_PACKET  = 2'd0,
      OP_RESOLVE = 2'd1,
      OP_TICK    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NONE  = 3'd0,
      ST_OKAY  = 3'd1,
      ST_WAIT  = 3'd2,
      ST_FAIL  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEND_NONE  = 2'd0,
      SEND_REPLY = 2'd1,
      SEND_QUERY = 2'd2
   } send_type;

   // classified command passed from front to back
   typedef enum logic [2:0] {
      CMD_NOP     = 3'd0,
      CMD_REFRESH = 3'd1,
      CMD_ADD     = 3'd2,
      CMD_RESOLVE = 3'd3,
      CMD_TICK    = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  ip;
      logic [47:0]  mac;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [47:0] resolved_mac;
      send_type    send_kind;
      logic [31:0] send_dst_ip;
      logic [47:0] send_dst_mac;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_ACT,
      BK_SWEEP,
      BK_OUT
   } bk_state_type;

   function automatic logic expired(input logic [31:0] now, input logic [31:0] dl);
      logic [31:0] diff;
      diff = now - dl;
      return ~diff[31];
   endfunction

endpackage

>>> hdl/arpc_front.sv
// arpc_front: accepts items, checks ARP headers and classifies into commands.
// Depends on arpc_pkg.
module arpc_front import arpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_proto_type,
   input  logic [7:0]  req_hw_len,
   input  logic [7:0]  req_proto_len,
   input  logic [15:0] req_arp_opcode,
   input  logic [31:0] req_src_ip,
   input  logic [47:0] req_src_mac,
   input  logic [31:0] req_dst_ip,
   input  logic [31:0] req_resolve_ip,
   input  logic [31:0] local_ip,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);

   // two-entry queue
   cmd_type   q_ff [2];
   cmd_type   q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type   c;
   logic      hdr_ok, is_req, is_rep, acc;

   assign req_stall = (cnt_ff == 2'd2);
   assign acc       = req_valid & ~req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[0];

   always_comb begin
      hdr_ok = (req_hw_type == ARP_HW_ETHER) && (req_proto_type == ARP_PROTO_IPV4) &&
               (req_hw_len == ARP_HW_LEN) && (req_proto_len == ARP_PROTO_LEN);
      is_req = req_arp_opcode == ARP_OPC_REQUEST;
      is_rep = req_arp_opcode == ARP_OPC_REPLY;
      c.kind = CMD_NOP;
      c.ip   = req_src_ip;
      c.mac  = req_src_mac;
      unique case (op_type'(req_operation))
         OP_PACKET: begin
            if (hdr_ok && is_req && local_ip != 32'd0 && req_dst_ip == local_ip)
               c.kind = CMD_ADD;
            else if (hdr_ok && (is_req || is_rep))
               c.kind = CMD_REFRESH;
         end
         OP_RESOLVE: begin
            c.kind = CMD_RESOLVE;
            c.ip   = req_resolve_ip;
         end
         OP_TICK: c.kind = CMD_TICK;
         default: c.kind = CMD_NOP;
      endcase
   end

   always_comb begin
      logic pop;
      logic [1:0] after;
      pop     = cmd_take & cmd_valid;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) q_in[0] = q_ff[1];
      after   = cnt_ff - {1'b0, pop};
      if (acc) q_in[after[0]] = c;
      cnt_in  = after + {1'b0, acc};
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end

endmodule

>>> hdl/arpc_back.sv
// arpc_back: table of slots, sequential lookup, allocation, query and sweep.
// Depends on arpc_pkg.
module arpc_back import arpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   input  logic [31:0] cache_timeout_ms,
   input  logic [15:0] query_interval_ms,
   input  logic [3:0]  max_attempts,
   input  logic [31:0] flush_interval_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp
);

   logic [ENTRIES-1:0] used_ff, used_in;
   logic [31:0] ip_ff  [ENTRIES];
   logic [47:0] mac_ff [ENTRIES];
   logic        val_ff [ENTRIES];
   logic [3:0]  att_ff [ENTRIES];
   logic [31:0] dl_ff  [ENTRIES];

   bk_state_type st_ff, st_in;
   cmd_type     c_ff, c_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic        hit_ff, hit_in, fre_ff, fre_in;
   logic [SLOT_W-1:0] hs_ff, hs_in, fs_ff, fs_in;
   logic [31:0] now_ff, now_in, nf_ff, nf_in;
   rsp_type     r_ff, r_in;

   logic [SLOT_W-1:0] ix, ts;
   logic        wr, wr_used;
   logic [31:0] w_ip, w_dl;
   logic [47:0] w_mac;
   logic        w_val;
   logic [3:0]  w_att;
   logic        clr;
   logic        tgt_ok;

   assign ix        = idx_ff[SLOT_W-1:0];
   assign cmd_take  = (st_ff == BK_IDLE) & cmd_valid;
   assign rsp_valid = (st_ff == BK_OUT);
   assign rsp       = r_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: if (cmd_valid) st_in = BK_SCAN;
         BK_SCAN: begin
            // flush check uses the clock after this tick
            if (c_ff.kind == CMD_TICK)
               st_in = expired(now_ff + 32'd1, nf_ff) ? BK_SWEEP : BK_OUT;
            else if (c_ff.kind == CMD_NOP) st_in = BK_OUT;
            else if (idx_ff == CNT_W'(ENTRIES - 1)) st_in = BK_ACT;
         end
         BK_ACT:   st_in = BK_OUT;
         BK_SWEEP: if (idx_ff == CNT_W'(ENTRIES - 1)) st_in = BK_OUT;
         BK_OUT:   if (!rsp_stall) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      c_in   = c_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      fre_in = fre_ff;
      hs_in  = hs_ff;
      fs_in  = fs_ff;
      now_in = now_ff;
      nf_in  = nf_ff;
      r_in   = r_ff;
      used_in = used_ff;
      wr = 1'b0;
      wr_used = 1'b0;
      ts = hit_ff ? hs_ff : fs_ff;
      w_ip = c_ff.ip;
      w_mac = c_ff.mac;
      w_val = 1'b1;
      w_att = 4'd0;
      w_dl = now_ff + cache_timeout_ms;
      clr = 1'b0;
      tgt_ok = 1'b0;
      unique case (st_ff)
         BK_IDLE: begin
            c_in   = cmd;
            idx_in = '0;
            hit_in = 1'b0;
            fre_in = 1'b0;
            r_in   = '0;
         end
         BK_SCAN: begin
            if (c_ff.kind == CMD_TICK) begin
               now_in = now_ff + 32'd1;
               idx_in = '0;
               if (expired(now_in, nf_ff)) nf_in = now_in + flush_interval_ms;
            end else begin
               if (!hit_ff && used_ff[ix] && ip_ff[ix] == c_ff.ip) begin
                  hit_in = 1'b1;
                  hs_in  = ix;
               end
               if (!fre_ff && !used_ff[ix]) begin
                  fre_in = 1'b1;
                  fs_in  = ix;
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         BK_ACT: begin
            unique case (c_ff.kind) inside
               CMD_REFRESH, CMD_ADD: begin
                  if (c_ff.kind == CMD_ADD) begin
                     r_in.send_kind    = SEND_REPLY;
                     r_in.send_dst_ip  = c_ff.ip;
                     r_in.send_dst_mac = c_ff.mac;
                  end
                  tgt_ok = hit_ff || (c_ff.kind == CMD_ADD && fre_ff);
                  if (tgt_ok) begin
                     wr = 1'b1;
                     wr_used = 1'b1;
                  end
               end
               CMD_RESOLVE: begin
                  w_val = 1'b0;
                  w_mac = '0;
                  w_dl  = now_ff + {16'd0, query_interval_ms};
                  if (!hit_ff) begin
                     if (!fre_ff) r_in.status = ST_FULL;
                     else begin
                        wr = 1'b1;
                        wr_used = 1'b1;
                        w_att = 4'd1;
                        r_in.status = ST_WAIT;
                        r_in.send_kind = SEND_QUERY;
                        r_in.send_dst_ip = c_ff.ip;
                     end
                  end else if (val_ff[hs_ff]) begin
                     r_in.status = ST_OKAY;
                     r_in.resolved_mac = mac_ff[hs_ff];
                  end else if (expired(now_ff, dl_ff[hs_ff])) begin
                     if (att_ff[hs_ff] >= max_attempts) r_in.status = ST_FAIL;
                     else begin
                        wr = 1'b1;
                        w_ip  = ip_ff[hs_ff];
                        w_mac = mac_ff[hs_ff];
                        w_att = att_ff[hs_ff] + 4'd1;
                        r_in.status = ST_WAIT;
                        r_in.send_kind = SEND_QUERY;
                        r_in.send_dst_ip = ip_ff[hs_ff];
                     end
                  end else r_in.status = ST_WAIT;
               end
               default: ;
            endcase
         end
         BK_SWEEP: begin
            clr = used_ff[ix] &&
                  ((val_ff[ix] && expired(now_ff, dl_ff[ix])) ||
                   (!val_ff[ix] && att_ff[ix] >= max_attempts));
            if (clr) used_in[ix] = 1'b0;
            idx_in = idx_ff + CNT_W'(1);
         end
         BK_OUT: ;
         default: ;
      endcase
      if (wr_used) used_in[ts] = 1'b1;
   end

   always_ff @(posedge clock) begin
      c_ff  <= c_in;
      hs_ff <= hs_in;
      fs_ff <= fs_in;
      r_ff  <= r_in;
      if (wr) begin
         ip_ff[ts]  <= w_ip;
         mac_ff[ts] <= w_mac;
         val_ff[ts] <= w_val;
         att_ff[ts] <= w_att;
         dl_ff[ts]  <= w_dl;
      end
      if (reset) begin
         st_ff   <= BK_IDLE;
         used_ff <= '0;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         fre_ff  <= 1'b0;
         now_ff  <= '0;
         nf_ff   <= FLUSH_INTERVAL_RST;
      end else begin
         st_ff   <= st_in;
         used_ff <= used_in;
         idx_ff  <= idx_in;
         hit_ff  <= hit_in;
         fre_ff  <= fre_in;
         now_ff  <= now_in;
         nf_ff   <= nf_in;
      end
   end

endmodule

>>> hdl/arp_cache_resolver_unit.sv
// ARP cache resolver top level. Packets and resolves go through the table
// engine's scan (one table slot compared per cycle) and act states; ticks
// go straight out, or through a flush sweep (one slot per cycle) first.
// The engine takes a new item only once the previous response is taken.
// A two-item queue decouples intake from the table engine.
// Synchronous reset empties the table, zeroes the clock and restores registers.
module arp_cache_resolver_unit import arpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_proto_type,
   input  logic [7:0]  req_hw_len,
   input  logic [7:0]  req_proto_len,
   input  logic [15:0] req_arp_opcode,
   input  logic [31:0] req_src_ip,
   input  logic [47:0] req_src_mac,
   input  logic [31:0] req_dst_ip,
   input  logic [31:0] req_resolve_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [47:0] rsp_resolved_mac,
   output logic [1:0]  rsp_send_kind,
   output logic [31:0] rsp_send_dst_ip,
   output logic [47:0] rsp_send_dst_mac
);

   logic [31:0] lip_ff, tmo_ff, fli_ff;
   logic [15:0] qi_ff;
   logic [3:0]  ma_ff;
   logic        cmd_valid, cmd_take;
   cmd_type     cmd;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         lip_ff <= '0;
         tmo_ff <= CACHE_TIMEOUT_RST;
         qi_ff  <= QUERY_INTERVAL_RST;
         ma_ff  <= MAX_ATTEMPTS_RST;
         fli_ff <= FLUSH_INTERVAL_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOCAL_IP: lip_ff <= csr_data;
            CSR_TIMEOUT:  tmo_ff <= csr_data;
            CSR_QUERY:    qi_ff  <= csr_data[15:0];
            CSR_ATTEMPTS: ma_ff  <= csr_data[3:0];
            CSR_FLUSH:    fli_ff <= csr_data;
            default: ;
         endcase
      end
   end

   arpc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_hw_type,
      .req_proto_type, .req_hw_len, .req_proto_len, .req_arp_opcode,
      .req_src_ip, .req_src_mac, .req_dst_ip, .req_resolve_ip,
      .local_ip(lip_ff), .cmd_valid, .cmd_take, .cmd
   );

   arpc_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .cache_timeout_ms(tmo_ff), .query_interval_ms(qi_ff),
      .max_attempts(ma_ff), .flush_interval_ms(fli_ff),
      .rsp_valid, .rsp_stall, .rsp
   );

   assign rsp_status       = rsp.status;
   assign rsp_resolved_mac = rsp.resolved_mac;
   assign rsp_send_kind    = rsp.send_kind;
   assign rsp_send_dst_ip  = rsp.send_dst_ip;
   assign rsp_send_dst_mac = rsp.send_dst_mac;

   a_okay_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OKAY |-> rsp_resolved_mac == 48'd0)
      else $error("mac without okay");
   a_query_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == SEND_QUERY |-> rsp_status == ST_WAIT)
      else $error("query without wait");
   a_reply_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == SEND_REPLY |-> rsp_status == ST_NONE)
      else $error("reply with status");

endmodule

>>> tb/arp_cache_resolver_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for arp_cache_resolver_unit: drives ARP packets,
// resolve requests and ticks, predicts each response, compares the whole struct.
// Depends on arpc_pkg and the RTL top level.
module arp_cache_resolver_unit_test;
   import arpc_pkg::*;

   typedef struct {
      op_type      op;
      logic [15:0] hw_type, proto_type, opcode;
      logic [7:0]  hw_len, proto_len;
      logic [31:0] src_ip, dst_ip, resolve_ip;
      logic [47:0] src_mac;
   } arp_item_type;

   class arp_scoreboard;
      logic [31:0] own_ip, timeout_ms, flush_ms, now_ms, next_flush;
      logic [15:0] query_ms;
      logic [3:0]  attempt_limit;
      bit          used[ENTRIES], valid[ENTRIES];
      logic [31:0] ip_of[ENTRIES], deadline[ENTRIES];
      logic [47:0] mac_of[ENTRIES];
      logic [3:0]  tries[ENTRIES];
      rsp_type     pending_rsp[$];
      int          mismatches;

      function void clear();
         own_ip = 0; timeout_ms = CACHE_TIMEOUT_RST; query_ms = QUERY_INTERVAL_RST;
         attempt_limit = MAX_ATTEMPTS_RST; flush_ms = FLUSH_INTERVAL_RST;
         now_ms = 0; next_flush = FLUSH_INTERVAL_RST;
         for (int i = 0; i < ENTRIES; i++) begin
            used[i] = 0; valid[i] = 0; ip_of[i] = 0; mac_of[i] = 0;
            tries[i] = 0; deadline[i] = 0;
         end
         pending_rsp.delete();
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_LOCAL_IP: own_ip = v;
            CSR_TIMEOUT:  timeout_ms = v;
            CSR_QUERY:    query_ms = v[15:0];
            CSR_ATTEMPTS: attempt_limit = v[3:0];
            CSR_FLUSH:    flush_ms = v;
            default: ;
         endcase
      endfunction

      function bit is_due(logic [31:0] d);
         logic [31:0] diff;
         diff = now_ms - d;
         return !diff[31];
      endfunction

      function int lookup(logic [31:0] ip);
         for (int i = 0; i < ENTRIES; i++) if (used[i] && ip_of[i] == ip) return i;
         return -1;
      endfunction

      function int first_free();
         for (int i = 0; i < ENTRIES; i++) if (!used[i]) return i;
         return -1;
      endfunction

      function void query(int s, ref rsp_type r);
         tries[s] = tries[s] + 4'd1;
         deadline[s] = now_ms + {16'd0, query_ms};
         r.send_kind = SEND_QUERY;
         r.send_dst_ip = ip_of[s];
         r.send_dst_mac = 0;
      endfunction

      function void note_input(arp_item_type it);
         rsp_type r;
         int      s;
         bit      may_add;
         r = '{status: ST_NONE, resolved_mac: 0, send_kind: SEND_NONE,
               send_dst_ip: 0, send_dst_mac: 0};
         case (it.op)
            OP_PACKET: begin
               if (it.hw_type == ARP_HW_ETHER && it.proto_type == ARP_PROTO_IPV4 &&
                   it.hw_len == ARP_HW_LEN && it.proto_len == ARP_PROTO_LEN &&
                   (it.opcode == ARP_OPC_REQUEST || it.opcode == ARP_OPC_REPLY)) begin
                  may_add = 0;
                  if (it.opcode == ARP_OPC_REQUEST && own_ip != 0 &&
                      it.dst_ip == own_ip) begin
                     r.send_kind = SEND_REPLY;
                     r.send_dst_ip = it.src_ip;
                     r.send_dst_mac = it.src_mac;
                     may_add = 1;
                  end
                  s = lookup(it.src_ip);
                  if (s < 0 && may_add) begin
                     s = first_free();
                     if (s >= 0) used[s] = 1;
                  end
                  if (s >= 0) begin
                     ip_of[s] = it.src_ip; mac_of[s] = it.src_mac;
                     valid[s] = 1; tries[s] = 0; deadline[s] = now_ms + timeout_ms;
                  end
               end
            end
            OP_RESOLVE: begin
               s = lookup(it.resolve_ip);
               if (s < 0) begin
                  s = first_free();
                  if (s < 0) r.status = ST_FULL;
                  else begin
                     used[s] = 1; ip_of[s] = it.resolve_ip; mac_of[s] = 0;
                     valid[s] = 0; tries[s] = 0;
                     query(s, r);
                     r.status = ST_WAIT;
                  end
               end else if (valid[s]) begin
                  r.status = ST_OKAY;
                  r.resolved_mac = mac_of[s];
               end else begin
                  r.status = ST_WAIT;
                  if (is_due(deadline[s])) begin
                     if (tries[s] >= attempt_limit) r.status = ST_FAIL;
                     else query(s, r);
                  end
               end
            end
            OP_TICK: begin
               now_ms = now_ms + 32'd1;
               if (is_due(next_flush)) begin
                  next_flush = now_ms + flush_ms;
                  for (int i = 0; i < ENTRIES; i++)
                     if (used[i] && ((valid[i] && is_due(deadline[i])) ||
                                     (!valid[i] && tries[i] >= attempt_limit)))
                        used[i] = 0;
               end
            end
            default: ;
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;
   logic        req_valid = 0, req_stall;
   logic [1:0]  req_operation = 0;
   logic [15:0] req_hw_type = 0, req_proto_type = 0, req_arp_opcode = 0;
   logic [7:0]  req_hw_len = 0, req_proto_len = 0;
   logic [31:0] req_src_ip = 0, req_dst_ip = 0, req_resolve_ip = 0;
   logic [47:0] req_src_mac = 0;
   logic        rsp_valid, rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_resolved_mac, rsp_send_dst_mac;
   logic [1:0]  rsp_send_kind;
   logic [31:0] rsp_send_dst_ip;

   arp_cache_resolver_unit dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   arp_scoreboard arp_model = new();
   int  send_idle_pct = 0, stall_pct = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;
   logic [31:0] ip_pool[8];

   // response side: sample and stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            arp_model.check_result('{status: status_type'(rsp_status),
               resolved_mac: rsp_resolved_mac, send_kind: send_type'(rsp_send_kind),
               send_dst_ip: rsp_send_dst_ip, send_dst_mac: rsp_send_dst_mac});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock)
      if (quiet_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end

   // csr_write is dropped after each write, so each call makes one register update
   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      arp_model.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send_item(arp_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_operation <= it.op;
      req_hw_type <= it.hw_type; req_proto_type <= it.proto_type;
      req_hw_len <= it.hw_len; req_proto_len <= it.proto_len;
      req_arp_opcode <= it.opcode; req_src_ip <= it.src_ip;
      req_src_mac <= it.src_mac; req_dst_ip <= it.dst_ip;
      req_resolve_ip <= it.resolve_ip;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      arp_model.note_input(it);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (arp_model.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic arp_item_type good_packet(logic [15:0] opc, logic [31:0] sip,
                                                logic [31:0] tip);
      arp_item_type it;
      it.op = OP_PACKET; it.hw_type = ARP_HW_ETHER; it.proto_type = ARP_PROTO_IPV4;
      it.hw_len = ARP_HW_LEN; it.proto_len = ARP_PROTO_LEN; it.opcode = opc;
      it.src_ip = sip; it.dst_ip = tip;
      it.src_mac = 48'({$urandom, $urandom});
      it.resolve_ip = $urandom;
      return it;
   endfunction

   function automatic arp_item_type random_item();
      arp_item_type it;
      int k;
      k = $urandom_range(99);
      it = good_packet(16'($urandom_range(1, 2)), ip_pool[$urandom_range(7)],
                       $urandom_range(3) == 0 ? $urandom : arp_model.own_ip);
      if (k < 30) it.op = OP_TICK;
      else if (k < 60) begin
         it.op = OP_RESOLVE;
         it.resolve_ip = $urandom_range(9) == 0 ? $urandom : ip_pool[$urandom_range(7)];
      end else if (k < 64) it.op = OP_NONE;
      else if (k < 72) begin
         // broken header or odd opcode: random bits, hw and proto type sometimes kept valid
         it.hw_type = 16'($urandom); it.proto_type = 16'($urandom);
         it.hw_len = 8'($urandom); it.proto_len = 8'($urandom);
         it.opcode = 16'($urandom);
         it.src_ip = $urandom; it.dst_ip = $urandom;
         if ($urandom_range(1)) it.hw_type = ARP_HW_ETHER;
         if ($urandom_range(1)) it.proto_type = ARP_PROTO_IPV4;
      end else if (k < 76) it.src_ip = $urandom;
      return it;
   endfunction

   initial begin
      arp_item_type it;
      arp_model.clear();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, no local ip, then extremes
      it = good_packet(ARP_OPC_REQUEST, 32'h0a000001, 0); send_item(it);
      it.op = OP_RESOLVE; it.resolve_ip = 32'h0a000001; send_item(it);
      it.op = OP_NONE; it.hw_type = '1; it.proto_type = '1; it.hw_len = '1;
      it.proto_len = '1; it.opcode = '1; it.src_ip = '1; it.src_mac = '1;
      it.dst_ip = '1; it.resolve_ip = '1; send_item(it);
      drain();
      write_reg(CSR_LOCAL_IP, 32'hffffffff);
      write_reg(CSR_TIMEOUT, 32'd3);
      write_reg(CSR_QUERY, 32'd1);
      write_reg(CSR_ATTEMPTS, 32'd1);
      write_reg(CSR_FLUSH, 32'd1);
      it = good_packet(ARP_OPC_REQUEST, 32'hffffffff, 32'hffffffff);
      it.src_mac = '1; send_item(it);
      it.op = OP_RESOLVE; it.resolve_ip = 32'hffffffff; send_item(it);
      it = good_packet(ARP_OPC_REPLY, 32'hffffffff, 0); it.src_mac = 0; send_item(it);
      it = good_packet(ARP_OPC_REQUEST, 32'h0, 32'hffffffff); send_item(it);
      it = good_packet(16'd3, 32'h5, 32'hffffffff); send_item(it);
      it = good_packet(ARP_OPC_REQUEST, 32'h6, 32'hffffffff); it.hw_len = 0; send_item(it);
      it.op = OP_RESOLVE; it.resolve_ip = 32'h0; send_item(it);
      send_item(it);
      it.op = OP_TICK; send_item(it); send_item(it);
      it.op = OP_RESOLVE; send_item(it); send_item(it);
      // fill the table
      for (int i = 0; i < ENTRIES + 1; i++) begin
         it.op = OP_RESOLVE; it.resolve_ip = 32'h100 + 32'(i); send_item(it);
      end
      it = good_packet(ARP_OPC_REQUEST, 32'h777, 32'hffffffff); send_item(it);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_LOCAL_IP, $urandom); write_reg(CSR_TIMEOUT, 32'd20);
               write_reg(CSR_QUERY, 32'd3); write_reg(CSR_ATTEMPTS, 32'd3);
               write_reg(CSR_FLUSH, 32'd7); end
            1: begin send_idle_pct = 58; write_reg(CSR_TIMEOUT, 32'hffffffff);
               write_reg(CSR_QUERY, 32'hffff); write_reg(CSR_ATTEMPTS, 32'd15); end
            2: begin send_idle_pct = 0; stall_pct = 58; write_reg(CSR_TIMEOUT, 32'h80000000);
               write_reg(CSR_FLUSH, 32'hffffffff); write_reg(CSR_QUERY, 32'd2);
               write_reg(CSR_ATTEMPTS, 32'd2); end
            3: begin send_idle_pct = 10; stall_pct = 10; write_reg(CSR_LOCAL_IP, 32'd0);
               write_reg(CSR_TIMEOUT, 32'd50); write_reg(CSR_FLUSH, 32'd5); end
            4: begin send_idle_pct = 0; stall_pct = 0; write_reg(CSR_LOCAL_IP, 32'h0a0a0a0a);
               write_reg(CSR_ATTEMPTS, 32'd15); write_reg(CSR_QUERY, 32'd1); end
            default: begin stall_pct = 30; send_idle_pct = 30; write_reg(CSR_ATTEMPTS, 32'd0);
               write_reg(CSR_TIMEOUT, 32'd10); write_reg(CSR_FLUSH, 32'd3); end
         endcase
         for (int i = 0; i < 8; i++)
            ip_pool[i] = i < 2 ? arp_model.own_ip + 32'(i) : $urandom;
         if (ph == 4) fork
            begin hold_off = 1; repeat (300) @(posedge clock); hold_off = 0; end
         join_none
         for (int n = 0; n < 160; n++) send_item(random_item());
         drain();
      end

      if (arp_model.mismatches == 0 && arp_model.pending_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
